// ----- src/assert_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold at every rising edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst_n, cond, msg) \
	`CHK_ASSERT(lbl, clk, rst_n, 1'b1 |-> (cond), msg)

`endif

// ----- src/scmm_pkg.sv -----
// Package with the types, sizes and codes of the sparse matrix multiplier.
package scmm_pkg;

	localparam int ENTRY_DEPTH  = 32;
	localparam int RESULT_DEPTH = 64;
	localparam int ENTRY_AW     = $clog2(ENTRY_DEPTH);
	localparam int ENTRY_CW     = $clog2(ENTRY_DEPTH + 1);
	localparam int RESULT_AW    = $clog2(RESULT_DEPTH);
	localparam int RESULT_CW    = $clog2(RESULT_DEPTH + 1);
	localparam int PADDR_W      = 4;

	localparam logic [1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [1:0] CMD_COMPUTE = 2'd2;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_MISMATCH = 2'd1;
	localparam logic [1:0] STS_EMPTY    = 2'd2;
	localparam logic [1:0] STS_OVERFLOW = 2'd3;

	localparam logic [1:0] REG_A_COLS = 2'd0;
	localparam logic [1:0] REG_B_ROWS = 2'd1;
	localparam logic [1:0] REG_COMMON = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic [7:0]         row_index;
		logic [7:0]         col_index;
		logic signed [31:0] entry_value;
	} item_t;

	typedef struct packed {
		logic [7:0]         out_row;
		logic [7:0]         out_col;
		logic signed [31:0] out_value;
		logic [1:0]         status;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [7:0]  row;
		logic [7:0]  col;
		logic [31:0] value;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [8:0]  a_cols;
		logic [8:0]  b_rows;
		logic [31:0] common_value;
	} cfg_t;

	typedef struct packed {
		logic                we;
		logic [ENTRY_AW-1:0] waddr;
		entry_t              wdata;
		logic                re;
		logic [ENTRY_AW-1:0] raddr;
	} entry_port_t;

	typedef struct packed {
		logic                 we;
		logic [RESULT_AW-1:0] waddr;
		entry_t               wdata;
		logic                 re;
		logic [RESULT_AW-1:0] raddr;
	} result_port_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ONE,
		ST_RD_A,
		ST_RD_B,
		ST_PAIR,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_DECIDE,
		ST_EM_RD,
		ST_EM_LD
	} state_t;

endpackage

// ----- src/sparse_coo_matrix_multiply.sv -----
// Top level of the sparse coordinate-format matrix multiplier.
// Usage: triplets arrive on the item channel (item_valid, item_ready, item).
// A load command stores one triplet of A or B; loads beyond 32 entries per
// matrix are ignored. A compute command checks the dimension registers and the
// entry counts, then walks every A entry against every B entry. Each A entry is
// read once, then each B entry is read and its row compared with the A column.
// A matching pair searches the result entries one by one (read, then compare),
// accumulating on a hit or, when none matches, adding a new entry if the product
// differs from the common value and the result memory has room. Emission reads
// each result entry, then loads it into the output register. Item_ready stays low
// from a compute transfer until its last result has been loaded into the output
// register. Results leave through a registered output (result_valid,
// result_ready, result); a stalled receiver holds the engine in emission but
// never loses a result. A mismatch or empty run gives one result with last set.
// Reset clears the counts and control state; the stores need no clearing pass.
// Configuration registers sit on the APB-style port at byte addresses 0, 4, 8.
module sparse_coo_matrix_multiply (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  scmm_pkg::item_t              item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output scmm_pkg::result_t            result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [scmm_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	scmm_pkg::cfg_t         cfg;
	scmm_pkg::entry_port_t  a_port, b_port;
	scmm_pkg::result_port_t p_port;
	scmm_pkg::entry_t       a_rd, b_rd, p_rd;

	scmm_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg
	);

	scmm_ram #(.WIDTH(scmm_pkg::ENTRY_W), .DEPTH(scmm_pkg::ENTRY_DEPTH)) u_a_ram (
		.clk, .we(a_port.we), .waddr(a_port.waddr), .wdata(a_port.wdata),
		.re(a_port.re), .raddr(a_port.raddr), .rdata(a_rd)
	);

	scmm_ram #(.WIDTH(scmm_pkg::ENTRY_W), .DEPTH(scmm_pkg::ENTRY_DEPTH)) u_b_ram (
		.clk, .we(b_port.we), .waddr(b_port.waddr), .wdata(b_port.wdata),
		.re(b_port.re), .raddr(b_port.raddr), .rdata(b_rd)
	);

	scmm_ram #(.WIDTH(scmm_pkg::ENTRY_W), .DEPTH(scmm_pkg::RESULT_DEPTH)) u_p_ram (
		.clk, .we(p_port.we), .waddr(p_port.waddr), .wdata(p_port.wdata),
		.re(p_port.re), .raddr(p_port.raddr), .rdata(p_rd)
	);

	scmm_engine u_engine (
		.clk, .arst_n, .cfg, .item_valid, .item_ready, .item,
		.result_valid, .result_ready, .result,
		.a_port, .a_rd, .b_port, .b_rd, .p_port, .p_rd
	);

endmodule

// ----- src/scmm_ram.sv -----
// Generic single-port-write, registered-read RAM.
module scmm_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/scmm_cfg.sv -----
// APB-style configuration registers.
module scmm_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [scmm_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output scmm_pkg::cfg_t               cfg
);

	scmm_pkg::cfg_t cfg_q;
	logic           wr;

	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a_cols       <= 9'd1;
			cfg_q.b_rows       <= 9'd1;
			cfg_q.common_value <= 32'd0;
		end else if (wr) begin
			case (paddr[3:2])
				scmm_pkg::REG_A_COLS: cfg_q.a_cols       <= pwdata[8:0];
				scmm_pkg::REG_B_ROWS: cfg_q.b_rows       <= pwdata[8:0];
				scmm_pkg::REG_COMMON: cfg_q.common_value <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			scmm_pkg::REG_A_COLS: prdata = {23'd0, cfg_q.a_cols};
			scmm_pkg::REG_B_ROWS: prdata = {23'd0, cfg_q.b_rows};
			scmm_pkg::REG_COMMON: prdata = cfg_q.common_value;
			default:              prdata = 32'd0;
		endcase
	end

endmodule

// ----- src/scmm_engine.sv -----
// Sequencer that loads entries, walks the pairs and accumulates into the result memory.
module scmm_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  scmm_pkg::cfg_t              cfg,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  scmm_pkg::item_t             item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output scmm_pkg::result_t           result,
	output scmm_pkg::entry_port_t       a_port,
	input  scmm_pkg::entry_t            a_rd,
	output scmm_pkg::entry_port_t       b_port,
	input  scmm_pkg::entry_t            b_rd,
	output scmm_pkg::result_port_t      p_port,
	input  scmm_pkg::entry_t            p_rd
);

	scmm_pkg::state_t                   state_q, state_nxt, loop_next;
	logic [scmm_pkg::ENTRY_CW-1:0]      a_count_q, b_count_q, i_q, j_q;
	logic [scmm_pkg::RESULT_CW-1:0]     pcount_q, k_q;
	logic                               ovf_q;
	logic [1:0]                         status_q;
	logic [31:0]                        prod_q;
	logic                               result_valid_q;
	scmm_pkg::result_t                  result_q;

	logic accept, is_cmp, to_one, pair_hit, scan_hit, last_j, last_i, scan_end;
	logic out_free, advance, loop_end, new_ok, room, grow;

	assign accept   = item_valid & item_ready;
	assign is_cmp   = item.command == scmm_pkg::CMD_COMPUTE;
	assign to_one   = (cfg.a_cols != cfg.b_rows) || (a_count_q == '0) || (b_count_q == '0);
	assign pair_hit = a_rd.col == b_rd.row;
	assign scan_hit = (p_rd.row == a_rd.row) && (p_rd.col == b_rd.col);
	assign last_j   = (j_q + 1'b1) == b_count_q;
	assign last_i   = (i_q + 1'b1) == a_count_q;
	assign scan_end = (k_q + 1'b1) == pcount_q;
	assign out_free = !result_valid_q || result_ready;
	assign room     = pcount_q < scmm_pkg::RESULT_CW'(scmm_pkg::RESULT_DEPTH);
	assign new_ok   = (prod_q != cfg.common_value) && room;
	assign grow     = (state_q == scmm_pkg::ST_DECIDE) && new_ok;
	assign advance  = (state_q == scmm_pkg::ST_PAIR && !pair_hit)
		|| (state_q == scmm_pkg::ST_SCAN_CMP && scan_hit)
		|| (state_q == scmm_pkg::ST_DECIDE);
	assign loop_end = advance && last_j && last_i;

	always_comb begin
		if (!last_j) begin
			loop_next = scmm_pkg::ST_RD_B;
		end else if (!last_i) begin
			loop_next = scmm_pkg::ST_RD_A;
		end else if (pcount_q == '0 && !grow) begin
			loop_next = scmm_pkg::ST_ONE;
		end else begin
			loop_next = scmm_pkg::ST_EM_RD;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			scmm_pkg::ST_IDLE: begin
				if (accept && is_cmp) begin
					state_nxt = to_one ? scmm_pkg::ST_ONE : scmm_pkg::ST_RD_A;
				end
			end
			scmm_pkg::ST_ONE: begin
				if (out_free) begin
					state_nxt = scmm_pkg::ST_IDLE;
				end
			end
			scmm_pkg::ST_RD_A:     state_nxt = scmm_pkg::ST_RD_B;
			scmm_pkg::ST_RD_B:     state_nxt = scmm_pkg::ST_PAIR;
			scmm_pkg::ST_PAIR: begin
				if (!pair_hit) begin
					state_nxt = loop_next;
				end else if (pcount_q == '0) begin
					state_nxt = scmm_pkg::ST_DECIDE;
				end else begin
					state_nxt = scmm_pkg::ST_SCAN_RD;
				end
			end
			scmm_pkg::ST_SCAN_RD:  state_nxt = scmm_pkg::ST_SCAN_CMP;
			scmm_pkg::ST_SCAN_CMP: begin
				if (scan_hit) begin
					state_nxt = loop_next;
				end else if (scan_end) begin
					state_nxt = scmm_pkg::ST_DECIDE;
				end else begin
					state_nxt = scmm_pkg::ST_SCAN_RD;
				end
			end
			scmm_pkg::ST_DECIDE:   state_nxt = loop_next;
			scmm_pkg::ST_EM_RD:    state_nxt = scmm_pkg::ST_EM_LD;
			scmm_pkg::ST_EM_LD: begin
				if (out_free) begin
					state_nxt = scan_end ? scmm_pkg::ST_IDLE : scmm_pkg::ST_EM_RD;
				end
			end
			default:               state_nxt = scmm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = state_q == scmm_pkg::ST_IDLE;

		a_port.we    = accept && item.command == scmm_pkg::CMD_LOAD_A
			&& a_count_q < scmm_pkg::ENTRY_CW'(scmm_pkg::ENTRY_DEPTH);
		a_port.waddr = a_count_q[scmm_pkg::ENTRY_AW-1:0];
		a_port.wdata = {item.row_index, item.col_index, item.entry_value};
		a_port.re    = state_q == scmm_pkg::ST_RD_A;
		a_port.raddr = i_q[scmm_pkg::ENTRY_AW-1:0];

		b_port.we    = accept && item.command == scmm_pkg::CMD_LOAD_B
			&& b_count_q < scmm_pkg::ENTRY_CW'(scmm_pkg::ENTRY_DEPTH);
		b_port.waddr = b_count_q[scmm_pkg::ENTRY_AW-1:0];
		b_port.wdata = {item.row_index, item.col_index, item.entry_value};
		b_port.re    = state_q == scmm_pkg::ST_RD_B;
		b_port.raddr = j_q[scmm_pkg::ENTRY_AW-1:0];

		p_port.re    = state_q == scmm_pkg::ST_SCAN_RD || state_q == scmm_pkg::ST_EM_RD;
		p_port.raddr = k_q[scmm_pkg::RESULT_AW-1:0];
		if (state_q == scmm_pkg::ST_SCAN_CMP) begin
			p_port.we    = scan_hit;
			p_port.waddr = k_q[scmm_pkg::RESULT_AW-1:0];
			p_port.wdata = {p_rd.row, p_rd.col, p_rd.value + prod_q};
		end else begin
			p_port.we    = state_q == scmm_pkg::ST_DECIDE && new_ok;
			p_port.waddr = pcount_q[scmm_pkg::RESULT_AW-1:0];
			p_port.wdata = {a_rd.row, b_rd.col, prod_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= scmm_pkg::ST_IDLE;
			a_count_q      <= '0;
			b_count_q      <= '0;
			i_q            <= '0;
			j_q            <= '0;
			k_q            <= '0;
			pcount_q       <= '0;
			ovf_q          <= 1'b0;
			status_q       <= scmm_pkg::STS_OK;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (a_port.we) begin
				a_count_q <= a_count_q + 1'b1;
			end
			if (b_port.we) begin
				b_count_q <= b_count_q + 1'b1;
			end
			if (accept && is_cmp) begin
				i_q      <= '0;
				j_q      <= '0;
				pcount_q <= '0;
				ovf_q    <= 1'b0;
				status_q <= (cfg.a_cols != cfg.b_rows) ? scmm_pkg::STS_MISMATCH
					: scmm_pkg::STS_EMPTY;
				if (to_one) begin
					a_count_q <= '0;
					b_count_q <= '0;
				end
			end
			if (advance) begin
				j_q <= last_j ? '0 : j_q + 1'b1;
				if (last_j) begin
					i_q <= i_q + 1'b1;
				end
			end
			if (loop_end) begin
				a_count_q <= '0;
				b_count_q <= '0;
				k_q       <= '0;
				status_q  <= scmm_pkg::STS_EMPTY;
			end
			if (state_q == scmm_pkg::ST_PAIR) begin
				k_q <= '0;
			end
			if (state_q == scmm_pkg::ST_SCAN_CMP && !scan_hit) begin
				k_q <= k_q + 1'b1;
			end
			if (state_q == scmm_pkg::ST_DECIDE && prod_q != cfg.common_value) begin
				if (room) begin
					pcount_q <= pcount_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if ((state_q == scmm_pkg::ST_ONE || state_q == scmm_pkg::ST_EM_LD) && out_free) begin
				result_valid_q <= 1'b1;
			end
			if (state_q == scmm_pkg::ST_EM_LD && out_free) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == scmm_pkg::ST_PAIR) begin
			prod_q <= a_rd.value * b_rd.value;
		end
		if (state_q == scmm_pkg::ST_ONE && out_free) begin
			result_q <= {8'd0, 8'd0, 32'sd0, status_q, 1'b1};
		end else if (state_q == scmm_pkg::ST_EM_LD && out_free) begin
			result_q <= {p_rd.row, p_rd.col, p_rd.value,
				ovf_q ? scmm_pkg::STS_OVERFLOW : scmm_pkg::STS_OK, scan_end};
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- src/scmm_checker.sv -----
// Port-level checker for the sparse matrix multiplier, bound to the top level.
`include "assert_macros.svh"

module scmm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_ready,
	input scmm_pkg::item_t              item,
	input logic                         result_valid,
	input logic                         result_ready,
	input scmm_pkg::result_t            result,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [scmm_pkg::PADDR_W-1:0] paddr,
	input logic [31:0]                  pwdata,
	input logic [31:0]                  prdata,
	input logic                         pready
);

	`CHK_ASSERT(a_result_hold, clk, arst_n, result_valid && !result_ready |=> result_valid && $stable(result), "Stalled result transfer changed.")
	`CHK_ASSERT(a_compute_busy, clk, arst_n, item_valid && item_ready && item.command == scmm_pkg::CMD_COMPUTE |=> !item_ready, "Block took an item straight after a compute transfer.")
	`CHK_ASSERT(a_mismatch_last, clk, arst_n, result_valid && result.status == scmm_pkg::STS_MISMATCH |-> result.last && result.out_value == 32'sd0, "Mismatch result is not a lone zero result.")
	`CHK_ASSERT(a_empty_last, clk, arst_n, result_valid && result.status == scmm_pkg::STS_EMPTY |-> result.last && result.out_row == 8'd0 && result.out_col == 8'd0, "Empty result is not a lone zero result.")
	`CHK_ALWAYS(a_pready, clk, arst_n, pready, "Configuration port inserted a wait state.")

endmodule

bind sparse_coo_matrix_multiply scmm_checker u_scmm_checker (.*);

// ----- dv/scmm_checker.sv -----
// Checker that predicts the multiplier's results from observed transfers and compares them.
`timescale 1ns / 100ps
module scmm_tb_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic                         item_ready,
	input  scmm_pkg::item_t              item,
	input  logic                         result_valid,
	input  logic                         result_ready,
	input  scmm_pkg::result_t            result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [scmm_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	input  logic                         pready,
	output int                           pending,
	output int                           failures
);

	scmm_pkg::cfg_t    cfg;
	scmm_pkg::entry_t  a_ent [scmm_pkg::ENTRY_DEPTH];
	scmm_pkg::entry_t  b_ent [scmm_pkg::ENTRY_DEPTH];
	int                a_num;
	int                b_num;
	scmm_pkg::entry_t  prod_ent [scmm_pkg::RESULT_DEPTH];
	int                prod_num;
	bit                dropped;
	scmm_pkg::result_t expected_q [$];

	function automatic scmm_pkg::result_t make_result(logic [7:0] r, logic [7:0] c,
			logic [31:0] v, logic [1:0] s, logic l);
		scmm_pkg::result_t res;
		res.out_row   = r;
		res.out_col   = c;
		res.out_value = v;
		res.status    = s;
		res.last      = l;
		return res;
	endfunction

	function automatic void add_product(logic [7:0] r, logic [7:0] c, logic [31:0] p);
		for (int k = 0; k < prod_num; k++) begin
			if (prod_ent[k].row == r && prod_ent[k].col == c) begin
				prod_ent[k].value = prod_ent[k].value + p;
				return;
			end
		end
		if (p == cfg.common_value)
			return;
		if (prod_num >= scmm_pkg::RESULT_DEPTH) begin
			dropped = 1'b1;
			return;
		end
		prod_ent[prod_num] = '{row: r, col: c, value: p};
		prod_num++;
	endfunction

	function automatic void predict_multiply();
		logic [31:0] p;
		prod_num = 0;
		dropped  = 1'b0;
		if (cfg.a_cols != cfg.b_rows) begin
			expected_q.push_back(make_result(8'd0, 8'd0, 32'd0, scmm_pkg::STS_MISMATCH, 1'b1));
		end else begin
			for (int i = 0; i < a_num; i++)
				for (int j = 0; j < b_num; j++)
					if (a_ent[i].col == b_ent[j].row) begin
						p = a_ent[i].value * b_ent[j].value;
						add_product(a_ent[i].row, b_ent[j].col, p);
					end
			if (prod_num == 0)
				expected_q.push_back(make_result(8'd0, 8'd0, 32'd0, scmm_pkg::STS_EMPTY,
					1'b1));
			else
				for (int k = 0; k < prod_num; k++)
					expected_q.push_back(make_result(prod_ent[k].row, prod_ent[k].col,
						prod_ent[k].value,
						dropped ? scmm_pkg::STS_OVERFLOW : scmm_pkg::STS_OK,
						k == prod_num - 1));
		end
		a_num = 0;
		b_num = 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		scmm_pkg::result_t want;
		if (!arst_n) begin
			cfg.a_cols       = 9'd1;
			cfg.b_rows       = 9'd1;
			cfg.common_value = 32'd0;
			a_num    = 0;
			b_num    = 0;
			prod_num = 0;
			dropped  = 1'b0;
			expected_q.delete();
			pending  = 0;
			failures = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					scmm_pkg::REG_A_COLS: cfg.a_cols = pwdata[8:0];
					scmm_pkg::REG_B_ROWS: cfg.b_rows = pwdata[8:0];
					scmm_pkg::REG_COMMON: cfg.common_value = pwdata;
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				case (item.command)
					scmm_pkg::CMD_LOAD_A: if (a_num < scmm_pkg::ENTRY_DEPTH) begin
						a_ent[a_num] = '{row: item.row_index, col: item.col_index,
							value: item.entry_value};
						a_num++;
					end
					scmm_pkg::CMD_LOAD_B: if (b_num < scmm_pkg::ENTRY_DEPTH) begin
						b_ent[b_num] = '{row: item.row_index, col: item.col_index,
							value: item.entry_value};
						b_num++;
					end
					scmm_pkg::CMD_COMPUTE: predict_multiply();
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with no result expected");
					failures++;
				end else begin
					want = expected_q.pop_front();
					if (result.out_row !== want.out_row) begin
						$error("out_row expected %0d actual %0d", want.out_row, result.out_row);
						failures++;
					end
					if (result.out_col !== want.out_col) begin
						$error("out_col expected %0d actual %0d", want.out_col, result.out_col);
						failures++;
					end
					if (result.out_value !== want.out_value) begin
						$error("out_value expected %0d actual %0d", want.out_value,
							result.out_value);
						failures++;
					end
					if (result.status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, result.status);
						failures++;
					end
					if (result.last !== want.last) begin
						$error("last expected %0d actual %0d", want.last, result.last);
						failures++;
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

// ----- dv/tb.sv -----
// Testbench top that drives the sparse matrix multiplier and reports the verdict.
`timescale 1ns / 100ps
module tb;

	localparam int         QUIET_LIMIT = 400000;
	localparam logic [1:0] CMD_SPARE   = 2'd3;

	logic                         clk;
	logic                         arst_n;
	logic                         item_valid;
	logic                         item_ready;
	scmm_pkg::item_t              item;
	logic                         result_valid;
	logic                         result_ready;
	scmm_pkg::result_t            result;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [scmm_pkg::PADDR_W-1:0] paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	int pending;
	int failures;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_reqs;
	int holds_done;
	int quiet_cycles;
	int items_sent;

	sparse_coo_matrix_multiply dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	scmm_tb_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.pending      (pending),
		.failures     (failures)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// The receiver holds off for a long stretch whenever the sender asks for it.
	initial begin
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done < hold_reqs) begin
				result_ready <= 1'b0;
				repeat (400) @(posedge clk);
				holds_done++;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(6) - 3;
			2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return $urandom_range(20);
		endcase
	endfunction

	task automatic send_item(logic [1:0] cmd, logic [7:0] r, logic [7:0] c, logic [31:0] v);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= '{command: cmd, row_index: r, col_index: c, entry_value: v};
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		item_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic compute();
		send_item(scmm_pkg::CMD_COMPUTE, 8'($urandom), 8'($urandom), $urandom);
	endtask

	task automatic run_set(int na, int nb);
		int span;
		span = ($urandom_range(7) == 0) ? 255 : 3;
		for (int k = 0; k < na + nb; k++) begin
			if ($urandom_range(11) == 0)
				send_item(CMD_SPARE, 8'($urandom), 8'($urandom), $urandom);
			send_item(k < na ? scmm_pkg::CMD_LOAD_A : scmm_pkg::CMD_LOAD_B,
				8'($urandom_range(span)), 8'($urandom_range(span)), pick_value());
		end
		compute();
	endtask

	initial begin
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_reqs      = 0;
		holds_done     = 0;
		quiet_cycles   = 0;
		items_sent     = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		compute();
		send_item(scmm_pkg::CMD_LOAD_A, 8'd0, 8'd0, 32'h7fff_ffff);
		send_item(scmm_pkg::CMD_LOAD_A, 8'd255, 8'd255, 32'h8000_0000);
		send_item(scmm_pkg::CMD_LOAD_B, 8'd0, 8'd255, 32'hffff_ffff);
		send_item(scmm_pkg::CMD_LOAD_B, 8'd255, 8'd0, 32'd7);
		compute();
		send_item(CMD_SPARE, 8'hff, 8'hff, 32'hffff_ffff);
		send_item(scmm_pkg::CMD_LOAD_A, 8'd1, 8'd2, 32'd0);
		send_item(scmm_pkg::CMD_LOAD_B, 8'd2, 8'd3, 32'd9);
		send_item(scmm_pkg::CMD_LOAD_A, 8'd4, 8'd5, 32'd5);
		send_item(scmm_pkg::CMD_LOAD_A, 8'd4, 8'd6, 32'd5);
		send_item(scmm_pkg::CMD_LOAD_B, 8'd5, 8'd7, 32'd1);
		send_item(scmm_pkg::CMD_LOAD_B, 8'd6, 8'd7, 32'hffff_ffff);
		compute();
		write_reg(scmm_pkg::REG_A_COLS, 32'd256);
		send_item(scmm_pkg::CMD_LOAD_A, 8'd3, 8'd3, 32'd1);
		send_item(scmm_pkg::CMD_LOAD_B, 8'd3, 8'd3, 32'd1);
		compute();
		write_reg(scmm_pkg::REG_B_ROWS, 32'd256);
		compute();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			case (ph)
				0: write_reg(scmm_pkg::REG_COMMON, 32'd1);
				1: write_reg(scmm_pkg::REG_COMMON, 32'h8000_0000);
				2: write_reg(scmm_pkg::REG_COMMON, 32'h7fff_ffff);
				3: write_reg(scmm_pkg::REG_COMMON, 32'hffff_ffff);
				default: write_reg(scmm_pkg::REG_COMMON,
					$urandom_range(1) ? 32'd0 : pick_value());
			endcase
			if (ph == 1) begin
				write_reg(scmm_pkg::REG_A_COLS, 32'd1);
				write_reg(scmm_pkg::REG_B_ROWS, 32'd1);
			end else if (ph == 4) begin
				write_reg(scmm_pkg::REG_A_COLS, 32'd200);
				write_reg(scmm_pkg::REG_B_ROWS, 32'd200);
			end else if (ph == 6) begin
				write_reg(scmm_pkg::REG_B_ROWS, 32'd17);
				run_set(2, 2);
				write_reg(scmm_pkg::REG_A_COLS, 32'd17);
			end
			if (ph == 2) begin
				hold_reqs++;
				run_set(3, 3);
				run_set(2, 2);
			end
			if (ph == 5) begin
				write_reg(scmm_pkg::REG_COMMON, 32'd0);
				for (int k = 0; k < 33; k++)
					send_item(scmm_pkg::CMD_LOAD_A, 8'(k), 8'd0, $urandom | 32'd1);
				for (int k = 0; k < 32; k++)
					send_item(scmm_pkg::CMD_LOAD_B, 8'd0, 8'(k), $urandom | 32'd1);
				compute();
			end
			while (items_sent < 17 + (ph + 1) * 8 + (ph >= 5 ? 66 : 0)) begin
				run_set($urandom_range(5), $urandom_range(5));
				if (ph == 3) begin
					item_valid <= 1'b0;
					@(posedge clk);
					wait (pending == 0);
					@(posedge clk);
				end
			end
		end

		item_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
